// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the pulse period histogram back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define PPH_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("pph assertion failed");

// Condition must never be seen at a clock edge outside reset.
`define PPH_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("pph forbidden condition seen");

`endif

// ===== rtl/core/pph_pkg.sv =====
// Types, codes and constants of the pulse period histogram.
`default_nettype none

package pph_pkg;

  localparam int KIND_W    = 2;
  localparam int PERIOD_W  = 16;
  localparam int INDEX_W   = 7;
  localparam int LIMIT_W   = 14;
  localparam int COUNT_W   = 10;
  localparam int BIN_IDX_W = 10;

  localparam int BIN_COUNT_DEF = 101;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QUEUE_AW      = $clog2(QUEUE_DEPTH);

  typedef logic [KIND_W-1:0]    kind_t;
  typedef logic [PERIOD_W-1:0]  period_t;
  typedef logic [INDEX_W-1:0]   index_t;
  typedef logic [LIMIT_W-1:0]   limit_t;
  typedef logic [COUNT_W-1:0]   count_t;
  typedef logic [BIN_IDX_W-1:0] bin_t;
  typedef logic [0:0]           cfg_index_t;

  localparam kind_t KIND_START   = kind_t'(0);
  localparam kind_t KIND_CAPTURE = kind_t'(1);
  localparam kind_t KIND_READ    = kind_t'(2);

  localparam cfg_index_t REG_PERIOD_FLOOR  = cfg_index_t'(0);
  localparam cfg_index_t REG_SAMPLE_TARGET = cfg_index_t'(1);

  localparam limit_t PERIOD_FLOOR_RST  = limit_t'(950);
  localparam count_t SAMPLE_TARGET_RST = count_t'(1000);

  typedef struct packed {
    kind_t  kind;
    logic   in_window;
    logic   idx_ok;
    bin_t   bin;
    limit_t bin_period;
  } job_t;

  typedef struct packed {
    logic   accepted;
    logic   done_res;
    count_t accepted_total;
    count_t bin_count;
    limit_t bin_period;
  } res_t;

  typedef struct packed {
    logic init_busy;
  } back_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/pph_ifs.sv =====
// Input and result channel interfaces of the pulse period histogram.
`default_nettype none

interface pph_in_if;
  logic             valid;
  logic             ready;
  pph_pkg::kind_t   kind;
  pph_pkg::period_t period;
  pph_pkg::index_t  bin_index;

  modport source (output valid, kind, period, bin_index, input ready);
  modport sink (input valid, kind, period, bin_index, output ready);
endinterface

interface pph_out_if;
  logic            valid;
  logic            ready;
  logic            accepted;
  logic            done_res;
  pph_pkg::count_t accepted_total;
  pph_pkg::count_t bin_count;
  pph_pkg::limit_t bin_period;

  modport source (output valid, accepted, done_res, accepted_total, bin_count, bin_period,
                  input ready);
  modport sink (input valid, accepted, done_res, accepted_total, bin_count, bin_period,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/core/pph_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module pph_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/pph_front.sv =====
// Front end: accepts input beats and classifies them into jobs.
`default_nettype none

module pph_front #(
  parameter int BIN_COUNT = pph_pkg::BIN_COUNT_DEF
) (
  pph_in_if.sink                     in_ch,
  input  wire pph_pkg::limit_t       period_floor,
  input  wire pph_pkg::back_status_t status,
  input  wire logic                  q_ready,
  output logic                       push,
  output pph_pkg::job_t              job
);

  pph_pkg::period_t limit_ext;
  pph_pkg::period_t diff;

  always_comb begin
    limit_ext = pph_pkg::period_t'(period_floor);
    diff      = pph_pkg::period_t'(in_ch.period - limit_ext);

    in_ch.ready = q_ready && !status.init_busy;
    push        = in_ch.valid && in_ch.ready;

    job.kind      = in_ch.kind;
    job.in_window = (in_ch.period >= limit_ext) && (32'(diff) < BIN_COUNT);
    job.idx_ok    = 32'(in_ch.bin_index) < BIN_COUNT;
    if (in_ch.kind == pph_pkg::KIND_READ) begin
      job.bin = pph_pkg::bin_t'(in_ch.bin_index);
    end else begin
      job.bin = diff[pph_pkg::BIN_IDX_W-1:0];
    end
    job.bin_period = pph_pkg::limit_t'(period_floor + pph_pkg::limit_t'(in_ch.bin_index));
  end

endmodule

`default_nettype wire

// ===== rtl/core/pph_queue.sv =====
// Short job queue between the front end and the back end.
`default_nettype none

module pph_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire pph_pkg::job_t push_job,
  output logic               ready,
  input  wire logic          pop,
  output logic               valid,
  output pph_pkg::job_t      head_job
);

  localparam int CNT_W = $clog2(pph_pkg::QUEUE_DEPTH + 1);

  pph_pkg::job_t                 mem_r [pph_pkg::QUEUE_DEPTH];
  logic [pph_pkg::QUEUE_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [pph_pkg::QUEUE_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;

  always_comb begin
    ready      = cnt_r != CNT_W'(pph_pkg::QUEUE_DEPTH);
    valid      = cnt_r != '0;
    head_job   = mem_r[rd_ptr_r];
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (32'(wr_ptr_r) == pph_pkg::QUEUE_DEPTH - 1) ? '0 :
                   pph_pkg::QUEUE_AW'(wr_ptr_r + 1'b1);
    end
    if (pop) begin
      rd_ptr_nxt = (32'(rd_ptr_r) == pph_pkg::QUEUE_DEPTH - 1) ? '0 :
                   pph_pkg::QUEUE_AW'(rd_ptr_r + 1'b1);
    end
    if (push && !pop) begin
      cnt_nxt = CNT_W'(cnt_r + 1'b1);
    end else if (pop && !push) begin
      cnt_nxt = CNT_W'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/pph_back.sv =====
// Back end: runs jobs against the bin memory and holds the result register.
`default_nettype none

`include "assert_macros.svh"

module pph_back #(
  parameter int BIN_COUNT = pph_pkg::BIN_COUNT_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire pph_pkg::count_t       sample_target,
  input  wire logic                  q_valid,
  input  wire pph_pkg::job_t         q_job,
  output logic                       pop,
  output pph_pkg::back_status_t      status,
  pph_out_if.source                  out_ch
);

  localparam int AW = $clog2(BIN_COUNT);

  localparam logic [2:0] ST_INIT = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_RMW  = 3'd2;
  localparam logic [2:0] ST_RD   = 3'd3;
  localparam logic [2:0] ST_CLR  = 3'd4;

  logic [2:0]      st_r, st_nxt;
  logic [AW-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic            synced_r, synced_nxt;
  logic            finished_r, finished_nxt;
  pph_pkg::count_t acc_cnt_r, acc_cnt_nxt;
  logic            out_valid_r, out_valid_nxt;
  pph_pkg::job_t   job_r, job_nxt;
  pph_pkg::res_t   res_r, res_nxt;

  logic            out_free;
  logic            load;
  logic            clr_last;
  pph_pkg::count_t acc_inc;
  pph_pkg::res_t   base_res;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  pph_pkg::count_t       ram_wdata;
  logic                  ram_re;
  logic [AW-1:0]         ram_raddr;
  pph_pkg::count_t       ram_rdata;

  pph_ram #(
    .WIDTH (pph_pkg::COUNT_W),
    .DEPTH (BIN_COUNT)
  ) u_bins (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (ram_re),
    .raddr   (ram_raddr),
    .rdata_r (ram_rdata)
  );

  always_comb begin
    out_free = !out_valid_r || out_ch.ready;
    clr_last = clr_cnt_r == AW'(BIN_COUNT - 1);
    acc_inc  = pph_pkg::count_t'(acc_cnt_r + 1'b1);

    base_res                = '0;
    base_res.done_res       = finished_r;
    base_res.accepted_total = acc_cnt_r;

    st_nxt       = st_r;
    clr_cnt_nxt  = clr_cnt_r;
    synced_nxt   = synced_r;
    finished_nxt = finished_r;
    acc_cnt_nxt  = acc_cnt_r;
    job_nxt      = job_r;
    res_nxt      = res_r;
    load         = 1'b0;
    pop          = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = clr_cnt_r;
    ram_wdata    = '0;
    ram_re       = 1'b0;
    ram_raddr    = q_job.bin[AW-1:0];

    case (st_r)
      ST_INIT, ST_CLR: begin
        ram_we = 1'b1;
        if (clr_last) begin
          st_nxt      = ST_IDLE;
          clr_cnt_nxt = '0;
        end else begin
          clr_cnt_nxt = AW'(clr_cnt_r + 1'b1);
        end
      end
      ST_IDLE: begin
        if (q_valid && out_free) begin
          pop     = 1'b1;
          job_nxt = q_job;
          case (q_job.kind)
            pph_pkg::KIND_START: begin
              synced_nxt   = 1'b0;
              finished_nxt = 1'b0;
              acc_cnt_nxt  = '0;
              load         = 1'b1;
              res_nxt      = '0;
              st_nxt       = ST_CLR;
              clr_cnt_nxt  = '0;
            end
            pph_pkg::KIND_CAPTURE: begin
              if (!synced_r) begin
                synced_nxt = 1'b1;
                load       = 1'b1;
                res_nxt    = base_res;
              end else if (finished_r) begin
                load    = 1'b1;
                res_nxt = base_res;
              end else if (acc_cnt_r >= sample_target) begin
                finished_nxt     = 1'b1;
                load             = 1'b1;
                res_nxt          = base_res;
                res_nxt.done_res = 1'b1;
              end else if (q_job.in_window) begin
                ram_re = 1'b1;
                st_nxt = ST_RMW;
              end else begin
                load    = 1'b1;
                res_nxt = base_res;
              end
            end
            pph_pkg::KIND_READ: begin
              if (q_job.idx_ok) begin
                ram_re = 1'b1;
                st_nxt = ST_RD;
              end else begin
                load               = 1'b1;
                res_nxt            = base_res;
                res_nxt.bin_period = q_job.bin_period;
              end
            end
            default: begin
              load    = 1'b1;
              res_nxt = base_res;
            end
          endcase
        end
      end
      ST_RMW: begin
        if (out_free) begin
          ram_we                 = 1'b1;
          ram_waddr              = job_r.bin[AW-1:0];
          ram_wdata              = pph_pkg::count_t'(ram_rdata + 1'b1);
          acc_cnt_nxt            = acc_inc;
          finished_nxt           = acc_inc >= sample_target;
          load                   = 1'b1;
          res_nxt                = '0;
          res_nxt.accepted       = 1'b1;
          res_nxt.done_res       = acc_inc >= sample_target;
          res_nxt.accepted_total = acc_inc;
          st_nxt                 = ST_IDLE;
        end
      end
      ST_RD: begin
        if (out_free) begin
          load               = 1'b1;
          res_nxt            = base_res;
          res_nxt.bin_count  = ram_rdata;
          res_nxt.bin_period = job_r.bin_period;
          st_nxt             = ST_IDLE;
        end
      end
      default: begin
        st_nxt      = ST_INIT;
        clr_cnt_nxt = '0;
      end
    endcase

    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end

    status.init_busy      = st_r == ST_INIT;
    out_ch.valid          = out_valid_r;
    out_ch.accepted       = res_r.accepted;
    out_ch.done_res       = res_r.done_res;
    out_ch.accepted_total = res_r.accepted_total;
    out_ch.bin_count      = res_r.bin_count;
    out_ch.bin_period     = res_r.bin_period;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_INIT;
      clr_cnt_r   <= '0;
      synced_r    <= 1'b0;
      finished_r  <= 1'b0;
      acc_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      synced_r    <= synced_nxt;
      finished_r  <= finished_nxt;
      acc_cnt_r   <= acc_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    res_r <= res_nxt;
  end

  `PPH_ASSERT_NEVER(a_no_ram_rw_same_cycle, clk, rst_n, ram_we && ram_re)
  `PPH_ASSERT_NEVER(a_no_result_while_clearing, clk, rst_n, (st_r == ST_INIT || st_r == ST_CLR) && load)
  `PPH_ASSERT(a_start_clears, clk, rst_n, (st_r == ST_IDLE && pop && q_job.kind == pph_pkg::KIND_START) |=> (st_r == ST_CLR && acc_cnt_r == '0 && !finished_r))
  `PPH_ASSERT(a_counted_increments, clk, rst_n, (st_r == ST_RMW && out_free) |=> (acc_cnt_r == pph_pkg::count_t'($past(acc_cnt_r) + 1'b1)))

endmodule

`default_nettype wire

// ===== rtl/core/pulse_period_histogram.sv =====
// Pulse period histogram: 1-tick bins above a configurable period floor.
// Items arrive as beats on in_ch (valid/ready) with kind, period and bin_index;
// kind start clears the histogram, capture bins a period, read returns one bin.
// Every accepted item yields exactly one result beat on out_ch, in order.
// The front end classifies each beat and queues it (two entries); the back end
// runs one job at a time against the bin RAM and loads the result register.
// Start, ignored captures and out-of-range reads load the result straight from
// idle; counted captures and in-range reads first pass through ST_RMW or ST_RD,
// which take a read-modify-write or a registered read of the bin RAM.
// The back end takes one plain job per cycle while out_ch is not stalled; a RAM
// job holds it until its result loads, and a start is followed by ST_CLR, which
// zeroes the RAM one bin per cycle. After reset the same sweep runs in ST_INIT
// with in_ch.ready low. When out_ch stalls, the result holds and the queue
// takes up to two more beats. cfg_we writes period_floor (index 0) or
// sample_target (index 1); write them only while the block is idle.
`default_nettype none

module pulse_period_histogram #(
  parameter int BIN_COUNT = pph_pkg::BIN_COUNT_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  pph_in_if.sink                    in_ch,
  pph_out_if.source                 out_ch,
  input  wire logic                 cfg_we,
  input  wire pph_pkg::cfg_index_t  cfg_index,
  input  wire pph_pkg::limit_t      cfg_wdata
);

  pph_pkg::limit_t       period_floor_r, period_floor_nxt;
  pph_pkg::count_t       sample_target_r, sample_target_nxt;

  pph_pkg::back_status_t status;
  pph_pkg::job_t         push_job;
  pph_pkg::job_t         head_job;
  logic                  push;
  logic                  pop;
  logic                  q_ready;
  logic                  q_valid;

  always_comb begin
    period_floor_nxt  = period_floor_r;
    sample_target_nxt = sample_target_r;
    if (cfg_we) begin
      case (cfg_index)
        pph_pkg::REG_PERIOD_FLOOR: begin
          period_floor_nxt = cfg_wdata;
        end
        pph_pkg::REG_SAMPLE_TARGET: begin
          sample_target_nxt = pph_pkg::count_t'(cfg_wdata);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_floor_r  <= pph_pkg::PERIOD_FLOOR_RST;
      sample_target_r <= pph_pkg::SAMPLE_TARGET_RST;
    end else begin
      period_floor_r  <= period_floor_nxt;
      sample_target_r <= sample_target_nxt;
    end
  end

  pph_front #(
    .BIN_COUNT (BIN_COUNT)
  ) u_front (
    .in_ch        (in_ch),
    .period_floor (period_floor_r),
    .status       (status),
    .q_ready      (q_ready),
    .push         (push),
    .job          (push_job)
  );

  pph_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .ready    (q_ready),
    .pop      (pop),
    .valid    (q_valid),
    .head_job (head_job)
  );

  pph_back #(
    .BIN_COUNT (BIN_COUNT)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .sample_target (sample_target_r),
    .q_valid       (q_valid),
    .q_job         (head_job),
    .pop           (pop),
    .status        (status),
    .out_ch        (out_ch)
  );

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench of the pulse period histogram: a directed table, then random phases.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BINS = pph_pkg::BIN_COUNT_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = BINS + 20;
  localparam pph_pkg::kind_t KIND_UNUSED = pph_pkg::kind_t'(3);
  localparam pph_pkg::res_t NO_RESULT = '0;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic                is_cfg;
    pph_pkg::cfg_index_t reg_idx;
    pph_pkg::limit_t     reg_val;
    pph_pkg::kind_t      kind;
    pph_pkg::period_t    period;
    pph_pkg::index_t     bin_index;
    logic                typed;
    pph_pkg::res_t       want;
  } stim_row_t;

  localparam stim_row_t DIRECTED [35] = '{
    '{1'b0, pph_pkg::REG_PERIOD_FLOOR, 14'd0, pph_pkg::KIND_READ, 16'd0, 7'd0, 1'b1,
      '{1'b0, 1'b0, 10'd0, 10'd0, 14'd950}},
    '{1'b0, pph_pkg::REG_PERIOD_FLOOR, 14'd0, pph_pkg::KIND_READ, 16'd0, 7'd100, 1'b1,
      '{1'b0, 1'b0, 10'd0, 10'd0, 14'd1050}},
    '{1'b0, pph_pkg::REG_PERIOD_FLOOR, 14'd0, pph_pkg::KIND_READ, 16'hffff, 7'd127, 1'b1,
      '{1'b0, 1'b0, 10'd0, 10'd0, 14'd1077}},
    '{1'b0, pph_pkg::REG_PERIOD_FLOOR, 14'd0, pph_pkg::KIND_CAPTURE, 16'd950, 7'd0, 1'b1,
      NO_RESULT},
    '{1'b0, pph_pkg::REG_PERIOD_FLOOR, 14'd0, pph_pkg::KIND_CAPTURE, 16'd950, 7'd0, 1'b1,
      '{1'b1, 1'b0, 10'd1, 10'd0, 14'd0}},
    '{1'b0, pph_pkg::REG_PERIOD_FLOOR, 14'd0, pph_pkg::KIND_CAPTURE, 16'd1050, 7'd127, 1'b1,
      '{1'b1, 1'b0, 10'd2, 10'd0, 14'd0}},
    '{1'b0, pph_pkg::REG_PERIOD_FLOOR, 14'd0, pph_pkg::KIND_CAPTURE, 16'd949, 7'd0, 1'b0,
      NO_RESULT},
    '{1'b0, pph_pkg::REG_PERIOD_FLOOR, 14'd0, pph_pkg::KIND_CAPTURE, 16'd1051, 7'd0, 1'b0,
      NO_RESULT},
    '{1'b0, pph_pkg::REG_PERIOD_FLOOR, 14'd0, pph_pkg::KIND_CAPTURE, 16'd0, 7'd0, 1'b0,
      NO_RESULT},
    '{1'b0, pph_pkg::REG_PERIOD_FLOOR, 14'd0, pph_pkg::KIND_CAPTURE, 16'hffff, 7'd0, 1'b0,
      NO_RESULT},
    '{1'b0, pph_pkg::REG_PERIOD_FLOOR, 14'd0, pph_pkg::KIND_READ, 16'd0, 7'd0, 1'b1,
      '{1'b0, 1'b0, 10'd2, 10'd1, 14'd950}},
    '{1'b0, pph_pkg::REG_PERIOD_FLOOR, 14'd0, pph_pkg::KIND_READ, 16'd0, 7'd100, 1'b1,
      '{1'b0, 1'b0, 10'd2, 10'd1, 14'd1050}},
    '{1'b0, pph_pkg::REG_PERIOD_FLOOR, 14'd0, KIND_UNUSED, 16'hffff, 7'd127, 1'b0,
      NO_RESULT},
    '{1'b0, pph_pkg::REG_PERIOD_FLOOR, 14'd0, pph_pkg::KIND_START, 16'hffff, 7'd127, 1'b1,
      NO_RESULT},
    '{1'b1, pph_pkg::REG_SAMPLE_TARGET, 14'd2, pph_pkg::KIND_START, 16'd0, 7'd0, 1'b0,
      NO_RESULT},
    '{1'b0, pph_pkg::REG_PERIOD_FLOOR, 14'd0, pph_pkg::KIND_CAPTURE, 16'd1000, 7'd0, 1'b0,
      NO_RESULT},
    '{1'b0, pph_pkg::REG_PERIOD_FLOOR, 14'd0, pph_pkg::KIND_CAPTURE, 16'd1000, 7'd0, 1'b1,
      '{1'b1, 1'b0, 10'd1, 10'd0, 14'd0}},
    '{1'b1, pph_pkg::REG_SAMPLE_TARGET, 14'd1, pph_pkg::KIND_START, 16'd0, 7'd0, 1'b0,
      NO_RESULT},
    '{1'b0, pph_pkg::REG_PERIOD_FLOOR, 14'd0, pph_pkg::KIND_CAPTURE, 16'd1000, 7'd0, 1'b1,
      '{1'b0, 1'b1, 10'd1, 10'd0, 14'd0}},
    '{1'b0, pph_pkg::REG_PERIOD_FLOOR, 14'd0, pph_pkg::KIND_CAPTURE, 16'd1001, 7'd0, 1'b0,
      NO_RESULT},
    '{1'b0, pph_pkg::REG_PERIOD_FLOOR, 14'd0, pph_pkg::KIND_READ, 16'd0, 7'd50, 1'b1,
      '{1'b0, 1'b1, 10'd1, 10'd1, 14'd1000}},
    '{1'b1, pph_pkg::REG_SAMPLE_TARGET, 14'd0, pph_pkg::KIND_START, 16'd0, 7'd0, 1'b0,
      NO_RESULT},
    '{1'b0, pph_pkg::REG_PERIOD_FLOOR, 14'd0, pph_pkg::KIND_START, 16'd0, 7'd0, 1'b0,
      NO_RESULT},
    '{1'b0, pph_pkg::REG_PERIOD_FLOOR, 14'd0, pph_pkg::KIND_CAPTURE, 16'd50, 7'd0, 1'b0,
      NO_RESULT},
    '{1'b0, pph_pkg::REG_PERIOD_FLOOR, 14'd0, pph_pkg::KIND_CAPTURE, 16'd1000, 7'd0, 1'b0,
      NO_RESULT},
    '{1'b1, pph_pkg::REG_PERIOD_FLOOR, 14'd16383, pph_pkg::KIND_START, 16'd0, 7'd0, 1'b0,
      NO_RESULT},
    '{1'b1, pph_pkg::REG_SAMPLE_TARGET, 14'd1000, pph_pkg::KIND_START, 16'd0, 7'd0, 1'b0,
      NO_RESULT},
    '{1'b0, pph_pkg::REG_PERIOD_FLOOR, 14'd0, pph_pkg::KIND_START, 16'd0, 7'd0, 1'b0,
      NO_RESULT},
    '{1'b0, pph_pkg::REG_PERIOD_FLOOR, 14'd0, pph_pkg::KIND_CAPTURE, 16'd16383, 7'd0, 1'b0,
      NO_RESULT},
    '{1'b0, pph_pkg::REG_PERIOD_FLOOR, 14'd0, pph_pkg::KIND_CAPTURE, 16'd16383, 7'd0, 1'b0,
      NO_RESULT},
    '{1'b0, pph_pkg::REG_PERIOD_FLOOR, 14'd0, pph_pkg::KIND_CAPTURE, 16'd16483, 7'd0, 1'b0,
      NO_RESULT},
    '{1'b0, pph_pkg::REG_PERIOD_FLOOR, 14'd0, pph_pkg::KIND_READ, 16'd0, 7'd127, 1'b0,
      NO_RESULT},
    '{1'b0, pph_pkg::REG_PERIOD_FLOOR, 14'd0, pph_pkg::KIND_READ, 16'd0, 7'd100, 1'b0,
      NO_RESULT},
    '{1'b1, pph_pkg::REG_PERIOD_FLOOR, 14'd50, pph_pkg::KIND_START, 16'd0, 7'd0, 1'b0,
      NO_RESULT},
    '{1'b0, pph_pkg::REG_PERIOD_FLOOR, 14'd0, pph_pkg::KIND_START, 16'd0, 7'd0, 1'b0,
      NO_RESULT}
  };

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  pph_pkg::cfg_index_t cfg_index;
  pph_pkg::limit_t     cfg_wdata;

  pph_in_if  in_ch();
  pph_out_if out_ch();

  pulse_period_histogram uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  pph_pkg::count_t bin_tally [BINS];
  pph_pkg::count_t tally_total;
  logic            sync_seen;
  logic            target_met;
  pph_pkg::limit_t cur_lower;
  pph_pkg::count_t cur_target;
  pph_pkg::res_t   pending_results [$];
  int              mismatches;
  int              send_idle_pct;
  int              stall_pct;
  int              cycles;

  function automatic pph_pkg::res_t predict_histogram_result(pph_pkg::kind_t kind,
                                                             pph_pkg::period_t period,
                                                             pph_pkg::index_t idx);
    pph_pkg::res_t r;
    int unsigned offset;
    r = NO_RESULT;
    offset = 32'(period) - 32'(cur_lower);
    case (kind)
      pph_pkg::KIND_START: begin
        foreach (bin_tally[b]) bin_tally[b] = '0;
        tally_total = '0;
        sync_seen = 1'b0;
        target_met = 1'b0;
      end
      pph_pkg::KIND_CAPTURE: begin
        if (!sync_seen) begin
          sync_seen = 1'b1;
        end else if (!target_met) begin
          if (tally_total >= cur_target) begin
            target_met = 1'b1;
          end else if (32'(period) >= 32'(cur_lower) && offset < BINS) begin
            bin_tally[offset] = bin_tally[offset] + 1'b1;
            tally_total = tally_total + 1'b1;
            r.accepted = 1'b1;
            if (tally_total >= cur_target) target_met = 1'b1;
          end
        end
      end
      pph_pkg::KIND_READ: begin
        if (idx < BINS) r.bin_count = bin_tally[idx];
        r.bin_period = pph_pkg::limit_t'(cur_lower + idx);
      end
      default: ;
    endcase
    r.done_res = target_met;
    r.accepted_total = tally_total;
    return r;
  endfunction

  function automatic void check_field(string name, logic [13:0] want, logic [13:0] got);
    if (got !== want) begin
      $display("%0t %s expected %0d got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  task automatic send_item(pph_pkg::kind_t kind, pph_pkg::period_t period,
                           pph_pkg::index_t idx, logic typed, pph_pkg::res_t want);
    pph_pkg::res_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.kind = kind;
    in_ch.period = period;
    in_ch.bin_index = idx;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predicted = predict_histogram_result(kind, period, idx);
    pending_results.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  task automatic drain_results();
    while (pending_results.size() != 0) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
  endtask

  task automatic write_reg(pph_pkg::cfg_index_t idx, pph_pkg::limit_t value);
    drain_results();
    in_ch.valid = 1'b0;
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == pph_pkg::REG_PERIOD_FLOOR) cur_lower = value;
    else cur_target = pph_pkg::count_t'(value);
  endtask

  task automatic run_phase(pph_pkg::limit_t lower, pph_pkg::count_t target, int items,
                           int capture_pct, logic restarts, idle_mode_t mode);
    pph_pkg::kind_t   kind;
    pph_pkg::period_t period;
    pph_pkg::index_t  idx;
    int unsigned      roll;
    write_reg(pph_pkg::REG_PERIOD_FLOOR, lower);
    write_reg(pph_pkg::REG_SAMPLE_TARGET, pph_pkg::limit_t'(target));
    send_idle_pct = (mode == IDLE_SENDER) ? 68 : (mode == IDLE_BOTH) ? 14 : 0;
    stall_pct = (mode == IDLE_RECEIVER) ? 68 : (mode == IDLE_BOTH) ? 14 : 0;
    send_item(pph_pkg::KIND_START, pph_pkg::period_t'($urandom),
              pph_pkg::index_t'($urandom), 1'b0, NO_RESULT);
    for (int i = 0; i < items; i++) begin
      period = pph_pkg::period_t'($urandom);
      idx = pph_pkg::index_t'($urandom);
      roll = $urandom_range(0, 99);
      if (roll < capture_pct) begin
        kind = pph_pkg::KIND_CAPTURE;
        roll = $urandom_range(0, 19);
        if (roll < 18) begin
          period = pph_pkg::period_t'(lower + $urandom_range(0, BINS - 1));
        end else if (roll == 18) begin
          period = $urandom_range(0, 1) ? pph_pkg::period_t'(lower - 1) :
                                          pph_pkg::period_t'(lower + BINS);
        end
      end else begin
        roll = $urandom_range(0, 9);
        if (roll < 7) begin
          kind = pph_pkg::KIND_READ;
          if (roll < 6) idx = pph_pkg::index_t'($urandom_range(0, BINS - 1));
        end else if (roll < 9) begin
          kind = restarts ? pph_pkg::KIND_START : pph_pkg::KIND_READ;
        end else begin
          kind = KIND_UNUSED;
        end
      end
      if ($urandom_range(0, 99) == 0) drain_results();
      send_item(kind, period, idx, 1'b0, NO_RESULT);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready = ($urandom_range(0, 99) >= stall_pct);
    end
  end

  initial begin : result_check
    pph_pkg::res_t got;
    pph_pkg::res_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got = '{out_ch.accepted, out_ch.done_res, out_ch.accepted_total, out_ch.bin_count,
                out_ch.bin_period};
        if (pending_results.size() == 0) begin
          $display("%0t result beat expected none got %p", $time, got);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("accepted", 14'(want.accepted), 14'(got.accepted));
          check_field("done_res", 14'(want.done_res), 14'(got.done_res));
          check_field("accepted_total", 14'(want.accepted_total), 14'(got.accepted_total));
          check_field("bin_count", 14'(want.bin_count), 14'(got.bin_count));
          check_field("bin_period", want.bin_period, got.bin_period);
        end
      end
    end
  end

  initial begin : watchdog
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("pulse_period_histogram: mismatch");
    $finish;
  end

  initial begin : stimulus
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = pph_pkg::REG_PERIOD_FLOOR;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.kind = pph_pkg::KIND_START;
    in_ch.period = '0;
    in_ch.bin_index = '0;
    mismatches = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    cur_lower = pph_pkg::PERIOD_FLOOR_RST;
    cur_target = pph_pkg::SAMPLE_TARGET_RST;
    foreach (bin_tally[b]) bin_tally[b] = '0;
    tally_total = '0;
    sync_seen = 1'b0;
    target_met = 1'b0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    send_idle_pct = 14;
    stall_pct = 14;
    foreach (DIRECTED[r]) begin
      if (DIRECTED[r].is_cfg) begin
        write_reg(DIRECTED[r].reg_idx, DIRECTED[r].reg_val);
      end else begin
        send_item(DIRECTED[r].kind, DIRECTED[r].period, DIRECTED[r].bin_index,
                  DIRECTED[r].typed, DIRECTED[r].want);
      end
    end

    // The long run without restarts fills the histogram up to the full target.
    run_phase(pph_pkg::PERIOD_FLOOR_RST, pph_pkg::SAMPLE_TARGET_RST, 1250, 97, 1'b0,
              IDLE_NONE);
    run_phase(pph_pkg::limit_t'(50), pph_pkg::count_t'(1), 60, 70, 1'b1, IDLE_SENDER);
    run_phase(pph_pkg::limit_t'(9950), pph_pkg::count_t'(17), 70, 70, 1'b1, IDLE_RECEIVER);
    run_phase(pph_pkg::limit_t'(16383), pph_pkg::count_t'(5), 60, 70, 1'b1, IDLE_BOTH);
    for (int p = 0; p < 5; p++) begin
      run_phase(pph_pkg::limit_t'($urandom_range(50, 9950)),
                (p == 4) ? pph_pkg::count_t'(0) : pph_pkg::count_t'($urandom_range(1, 40)),
                60, 70, 1'b1, idle_mode_t'(1 + p % 3));
    end

    stall_pct = 0;
    in_ch.valid = 1'b0;
    drain_results();
    repeat (10) @(negedge clk);
    if (mismatches == 0) begin
      $display("pulse_period_histogram: match");
    end else begin
      $display("pulse_period_histogram: mismatch");
    end
    $finish;
  end

endmodule
